>>> hw/rtl/rddsf_pkg.sv
package rddsf_pkg;

    // field and datapath widths
    localparam int SPD_W     = 24;
    localparam int DIFF_W    = SPD_W + 2;
    localparam int STEP_W    = 23;
    localparam int BAND_W    = 23;
    localparam int AXIS_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;
    localparam int NUM_W     = 37;   // adv*512 +/- rot*axis, exact
    localparam int MAG_W     = 36;
    localparam int X_W       = 43;   // magnitude times 100
    localparam int CAP_W     = 23;   // radius times 1999
    localparam int FRAC_SH   = 17;
    localparam int DEN_W     = AXIS_W + FRAC_SH;
    localparam int Q_W       = 10;
    localparam int DSR_W     = DEN_W + Q_W - 1;
    localparam int REM_W     = DSR_W + 1;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 4;
    localparam int ADV_SH    = 9;

    localparam logic [Q_W-1:0]   SPEED_CAP   = 10'd999;
    localparam logic [CNT_W-1:0] DIV_LAST    = 4'd9;
    localparam logic [IDX_W-1:0] FRAME_LAST  = 4'd14;
    localparam logic [X_W-1:0]   CENT        = 43'd100;
    localparam logic [CAP_W-1:0] SAT_LIMIT2  = 23'd1999;  // twice 999.5

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_ADV  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_ROT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADV_DONE_BAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_DONE_BAND = 3'd5;

    // frame characters
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic [STEP_W-1:0] max_step_adv;
        logic [STEP_W-1:0] max_step_rot;
        logic [AXIS_W-1:0] axis_length;
        logic [AXIS_W-1:0] wheel_radius;
        logic [BAND_W-1:0] adv_done_band;
        logic [BAND_W-1:0] rot_done_band;
    } cfg_t;

    typedef struct packed {
        logic             left_neg;
        logic [MAG_W-1:0] left_mag;
        logic             right_neg;
        logic [MAG_W-1:0] right_mag;
    } job_t;

    typedef struct packed {
        logic       neg;
        logic       sat;
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } wheel_res_t;

    typedef struct packed {
        wheel_res_t left;
        wheel_res_t right;
    } frame_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_HAND
    } back_state_t;

    typedef enum logic [2:0] {
        W_IDLE,
        W_MUL,
        W_CHK,
        W_DIV,
        W_RND,
        W_DIG,
        W_TEN
    } wheel_state_t;

    // measured value moved toward the goal by at most one step
    function automatic logic signed [SPD_W-1:0] ramp_to(
        input logic signed [SPD_W-1:0] goal,
        input logic signed [SPD_W-1:0] meas,
        input logic [STEP_W-1:0]       step
    );
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] s;
        logic signed [DIFF_W-1:0] m;
        d = DIFF_W'(goal) - DIFF_W'(meas);
        s = $signed({3'b000, step});
        m = DIFF_W'(meas);
        if (d > s)
            ramp_to = SPD_W'(m + s);
        else if (-d > s)
            ramp_to = SPD_W'(m - s);
        else
            ramp_to = goal;
    endfunction

    function automatic logic [SPD_W:0] abs_diff(
        input logic signed [SPD_W-1:0] a,
        input logic signed [SPD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        abs_diff = (d < 0) ? (SPD_W+1)'(-d) : (SPD_W+1)'(d);
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        digit_char = CH_ZERO + {4'b0000, d};
    endfunction

    function automatic logic [7:0] frame_char(input frame_t f, input logic [IDX_W-1:0] idx);
        case (idx)
            4'd0:    frame_char = CH_C;
            4'd1:    frame_char = CH_ONE;
            4'd2:    frame_char = CH_COLON;
            4'd3:    frame_char = f.left.neg ? CH_MINUS : CH_PLUS;
            4'd4:    frame_char = digit_char(f.left.hun);
            4'd5:    frame_char = digit_char(f.left.ten);
            4'd6:    frame_char = digit_char(f.left.one);
            4'd7:    frame_char = f.right.neg ? CH_MINUS : CH_PLUS;
            4'd8:    frame_char = digit_char(f.right.hun);
            4'd9:    frame_char = digit_char(f.right.ten);
            4'd10:   frame_char = digit_char(f.right.one);
            4'd11:   frame_char = CH_ONE;
            4'd12:   frame_char = CH_STAR;
            default: frame_char = CH_X;
        endcase
    endfunction

endpackage

>>> hw/rtl/rddsf_front.sv
module rddsf_front
    import rddsf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SPD_W-1:0] goal_adv,
    input  logic signed [SPD_W-1:0] goal_rot,
    input  logic signed [SPD_W-1:0] meas_adv,
    input  logic signed [SPD_W-1:0] meas_rot,
    input  logic                    new_goal,
    output logic                    push,
    output job_t                    push_job,
    input  logic                    full
);

    front_state_t state_reg, state_next;
    logic                    active_reg;
    logic signed [SPD_W-1:0] adv_reg, rot_reg;
    logic signed [NUM_W-1:0] spin_reg, left_reg, right_reg;

    logic accept, armed, settled;
    logic signed [NUM_W-1:0] spin_w, adv_sh_w;

    assign accept  = in_valid && in_ready;
    assign armed   = new_goal || active_reg;
    assign settled = !((abs_diff(meas_adv, goal_adv) > {2'b00, cfg.adv_done_band}) ||
                       (abs_diff(meas_rot, goal_rot) > {2'b00, cfg.rot_done_band}));

    assign spin_w   = NUM_W'(rot_reg) * NUM_W'($signed({1'b0, cfg.axis_length}));
    assign adv_sh_w = NUM_W'(adv_reg) <<< ADV_SH;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept && armed) state_next = F_MUL;
            F_MUL:   state_next = F_SUM;
            F_SUM:   state_next = F_PUSH;
            F_PUSH:  if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready           = (state_reg == F_IDLE);
        push               = (state_reg == F_PUSH) && !full;
        push_job.left_neg  = left_reg[NUM_W-1];
        push_job.left_mag  = MAG_W'(left_reg[NUM_W-1] ? -left_reg : left_reg);
        push_job.right_neg = right_reg[NUM_W-1];
        push_job.right_mag = MAG_W'(right_reg[NUM_W-1] ? -right_reg : right_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            active_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                active_reg <= armed && !settled;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            adv_reg <= ramp_to(goal_adv, meas_adv, cfg.max_step_adv);
            rot_reg <= ramp_to(goal_rot, meas_rot, cfg.max_step_rot);
        end
        if (state_reg == F_MUL)
            spin_reg <= spin_w;
        if (state_reg == F_SUM)
        begin
            left_reg  <= adv_sh_w - spin_reg;
            right_reg <= adv_sh_w + spin_reg;
        end
    end

endmodule

>>> hw/rtl/rddsf_queue.sv
module rddsf_queue
    import rddsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> hw/rtl/rddsf_wheel.sv
module rddsf_wheel
    import rddsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              neg,
    input  logic [MAG_W-1:0]  mag,
    input  logic [AXIS_W-1:0] radius,
    output logic              busy,
    output wheel_res_t        res
);

    wheel_state_t state_reg, state_next;
    logic              neg_reg, sat_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [AXIS_W-1:0] rad_reg;
    logic [X_W-1:0]    x_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [Q_W-1:0]    q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [3:0]        hun_reg;
    logic [6:0]        rest_reg;
    wheel_res_t        res_reg;

    logic [DEN_W-1:0] den;
    logic             sat_w, ge_w, inc_w;
    logic [DEN_W:0]   half2_w;
    logic [15:0]      hun_prod;
    logic [14:0]      ten_prod;
    logic [3:0]       hun_w, ten_w;
    logic [6:0]       rest_w;

    assign den     = {rad_reg, {FRAC_SH{1'b0}}};
    // rounded speed exceeds the cap iff 2*x >= 1999*den
    assign sat_w   = {x_reg, 1'b0} >= {4'b0000, cap_reg, {FRAC_SH{1'b0}}};
    assign ge_w    = rem_reg >= {1'b0, dsr_reg};
    // round half to even on the final remainder
    assign half2_w = {rem_reg[DEN_W-1:0], 1'b0};
    assign inc_w   = (half2_w > {1'b0, den}) || ((half2_w == {1'b0, den}) && q_reg[0]);

    // digit split by reciprocal multiply, exact below 1000
    assign hun_prod = {6'b000000, q_reg} * 16'd41;
    assign hun_w    = hun_prod[15:12];
    assign rest_w   = 7'(q_reg - ({6'b000000, hun_w} * 10'd100));
    assign ten_prod = {8'b00000000, rest_reg} * 15'd205;
    assign ten_w    = ten_prod[14:11];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            W_IDLE:  if (start) state_next = W_MUL;
            W_MUL:   state_next = W_CHK;
            W_CHK:   state_next = sat_w ? W_DIG : W_DIV;
            W_DIV:   if (cnt_reg == '0) state_next = W_RND;
            W_RND:   state_next = W_DIG;
            W_DIG:   state_next = W_TEN;
            W_TEN:   state_next = W_IDLE;
            default: state_next = W_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != W_IDLE);
        res  = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= W_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= neg;
                    mag_reg <= mag;
                    rad_reg <= (radius == '0) ? AXIS_W'(1) : radius;
                end
            end
            W_MUL:
            begin
                x_reg   <= {7'b0000000, mag_reg} * CENT;
                cap_reg <= {11'b00000000000, rad_reg} * SAT_LIMIT2;
            end
            W_CHK:
            begin
                sat_reg <= sat_w;
                rem_reg <= x_reg[REM_W-1:0];
                dsr_reg <= {den, {(Q_W-1){1'b0}}};
                cnt_reg <= DIV_LAST;
                q_reg   <= sat_w ? SPEED_CAP : '0;
            end
            W_DIV:
            begin
                if (ge_w)
                    rem_reg <= rem_reg - {1'b0, dsr_reg};
                q_reg   <= {q_reg[Q_W-2:0], ge_w};
                dsr_reg <= dsr_reg >> 1;
                cnt_reg <= cnt_reg - 4'd1;
            end
            W_RND:
            begin
                q_reg <= q_reg + {{(Q_W-1){1'b0}}, inc_w};
            end
            W_DIG:
            begin
                hun_reg  <= hun_w;
                rest_reg <= rest_w;
            end
            W_TEN:
            begin
                res_reg.neg <= neg_reg;
                res_reg.sat <= sat_reg;
                res_reg.hun <= hun_reg;
                res_reg.ten <= ten_w;
                res_reg.one <= 4'(rest_reg - ({3'b000, ten_w} * 7'd10));
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> hw/rtl/rddsf_back.sv
module rddsf_back
    import rddsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [AXIS_W-1:0] wheel_radius,
    input  logic              empty,
    input  job_t              pop_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        frame_byte,
    output logic              last_byte,
    output logic              saturated
);

    back_state_t state_reg, state_next;
    logic             fb_valid_reg;
    frame_t           fb_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [7:0]       frame_byte_reg;
    logic             last_byte_reg;
    logic             saturated_reg;

    logic       start, fb_load, load_out, busy_l, busy_r;
    wheel_res_t res_l, res_r;

    rddsf_wheel u_wheel_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .neg    (pop_job.left_neg),
        .mag    (pop_job.left_mag),
        .radius (wheel_radius),
        .busy   (busy_l),
        .res    (res_l)
    );

    rddsf_wheel u_wheel_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .neg    (pop_job.right_neg),
        .mag    (pop_job.right_mag),
        .radius (wheel_radius),
        .busy   (busy_r),
        .res    (res_r)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!empty) state_next = B_RUN;
            B_RUN:   if (!busy_l && !busy_r) state_next = B_HAND;
            B_HAND:  if (!fb_valid_reg) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop     = (state_reg == B_IDLE) && !empty;
        start   = pop;
        fb_load = (state_reg == B_HAND) && !fb_valid_reg;
    end

    // byte serialiser: next byte loads as the output register empties
    assign load_out = fb_valid_reg && (!out_valid_reg || out_ready);

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = last_byte_reg;
    assign saturated  = saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fb_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fb_load)
                fb_valid_reg <= 1'b1;
            else if (load_out && (idx_reg == FRAME_LAST))
                fb_valid_reg <= 1'b0;
            if (load_out)
                idx_reg <= (idx_reg == FRAME_LAST) ? '0 : idx_reg + 4'd1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fb_load)
        begin
            fb_reg.left  <= res_l;
            fb_reg.right <= res_r;
        end
        if (load_out)
        begin
            frame_byte_reg <= frame_char(fb_reg, idx_reg);
            last_byte_reg  <= (idx_reg == FRAME_LAST);
            saturated_reg  <= fb_reg.left.sat || fb_reg.right.sat;
        end
    end

endmodule

>>> hw/rtl/ramped_diff_drive_speed_framer_top.sv
// Path: a tick transfer runs the front states MUL, SUM and PUSH (PUSH waits while the queue
// is full), the queue, the wheel units, the handover and the output register; the 15 bytes
// then follow one per cycle while out_ready stays high. Throughput is set by the ten-step
// quotient loop of the wheel units; a tick with the ramp disarmed is taken, giving no frame.
// Reset: asynchronous, clears control state, loads register defaults and arms the ramp.
module ramped_diff_drive_speed_framer_top
    import rddsf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SPD_W-1:0] goal_adv,
    input  logic signed [SPD_W-1:0] goal_rot,
    input  logic signed [SPD_W-1:0] meas_adv,
    input  logic signed [SPD_W-1:0] meas_rot,
    input  logic                    new_goal,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              frame_byte,
    output logic                    last_byte,
    output logic                    saturated
);

    cfg_t cfg_reg;
    logic push, full, pop, empty;
    job_t push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_step_adv  <= 23'd256;
            cfg_reg.max_step_rot  <= 23'd655;
            cfg_reg.axis_length   <= 12'd400;
            cfg_reg.wheel_radius  <= 12'd100;
            cfg_reg.adv_done_band <= 23'd128;
            cfg_reg.rot_done_band <= 23'd655;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_STEP_ADV:  cfg_reg.max_step_adv  <= cfg_data;
                REG_MAX_STEP_ROT:  cfg_reg.max_step_rot  <= cfg_data;
                REG_AXIS_LENGTH:   cfg_reg.axis_length   <= cfg_data[AXIS_W-1:0];
                REG_WHEEL_RADIUS:  cfg_reg.wheel_radius  <= cfg_data[AXIS_W-1:0];
                REG_ADV_DONE_BAND: cfg_reg.adv_done_band <= cfg_data;
                REG_ROT_DONE_BAND: cfg_reg.rot_done_band <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rddsf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .goal_adv (goal_adv),
        .goal_rot (goal_rot),
        .meas_adv (meas_adv),
        .meas_rot (meas_rot),
        .new_goal (new_goal),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    rddsf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    rddsf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wheel_radius (cfg_reg.wheel_radius),
        .empty        (empty),
        .pop_job      (pop_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .saturated    (saturated)
    );

endmodule
